FILE: src/ecr_pkg.sv
// Shared types, constants and color-stop tables for the elevation color ramp.
// No dependencies; every other file in this block imports this package.
package ecr_pkg;

  // Sample and sea-level width, signed fixed point with 4 fraction bits
  localparam int ELEV_BITS  = 20;
  // Signed width of height/depth differences and spans
  localparam int SPAN_W     = ELEV_BITS + 2;
  // Unsigned width of a clamped numerator or denominator
  localparam int NUM_W      = ELEV_BITS + 1;
  // Blend factor: Q_BITS quotient bits, plus one bit for exactly 1.0
  localparam int Q_BITS     = 16;
  localparam int U_W        = Q_BITS + 1;
  localparam int FRAC_SCALE = 16;

  // Breakpoints and spans in 1/16 m
  localparam logic signed [SPAN_W-1:0] SHALLOW_SPAN  = SPAN_W'(200 * FRAC_SCALE);
  localparam logic signed [SPAN_W-1:0] LAND_B1       = SPAN_W'(200 * FRAC_SCALE);
  localparam logic signed [SPAN_W-1:0] LAND_B2       = SPAN_W'(800 * FRAC_SCALE);
  localparam logic signed [SPAN_W-1:0] LAND_B3       = SPAN_W'(2000 * FRAC_SCALE);
  localparam logic signed [SPAN_W-1:0] LAND_B4       = SPAN_W'(4000 * FRAC_SCALE);
  localparam logic signed [SPAN_W-1:0] LAND_B5       = SPAN_W'(6000 * FRAC_SCALE);
  localparam logic signed [SPAN_W-1:0] TOP_SPAN      = SPAN_W'(3000 * FRAC_SCALE);
  // Deep-ocean span is datum - floor - shallow span
  localparam logic signed [SPAN_W-1:0] OCEAN_DEN_OFS =
    SPAN_W'((6000 - 200) * FRAC_SCALE);

  typedef logic [7:0] chan_t;

  typedef struct packed {
    chan_t red;
    chan_t green;
    chan_t blue;
  } rgb_t;

  // Color stops
  localparam rgb_t C_SHALLOW = '{red: 8'd70,  green: 8'd150, blue: 8'd245};
  localparam rgb_t C_MID     = '{red: 8'd30,  green: 8'd80,  blue: 8'd180};
  localparam rgb_t C_DEEP    = '{red: 8'd5,   green: 8'd15,  blue: 8'd80};
  localparam rgb_t C_DKGREEN = '{red: 8'd20,  green: 8'd100, blue: 8'd30};
  localparam rgb_t C_GREEN   = '{red: 8'd50,  green: 8'd170, blue: 8'd60};
  localparam rgb_t C_YELLOW  = '{red: 8'd220, green: 8'd200, blue: 8'd40};
  localparam rgb_t C_ORANGE  = '{red: 8'd210, green: 8'd120, blue: 8'd30};
  localparam rgb_t C_RED     = '{red: 8'd190, green: 8'd50,  blue: 8'd30};
  localparam rgb_t C_PURPLE  = '{red: 8'd140, green: 8'd60,  blue: 8'd170};
  localparam rgb_t C_WHITE   = '{red: 8'd255, green: 8'd255, blue: 8'd255};

  // Ramp segment a sample falls into
  typedef enum logic [2:0] {
    SEG_SHALLOW,
    SEG_DEEP,
    SEG_LAND0,
    SEG_LAND1,
    SEG_LAND2,
    SEG_LAND3,
    SEG_LAND4,
    SEG_LAND5
  } seg_t;

  typedef struct packed {
    logic signed [ELEV_BITS-1:0] elevation;
    logic                        end_of_frame;
  } in_word_t;

  typedef struct packed {
    chan_t red;
    chan_t green;
    chan_t blue;
    logic  frame_done;
  } out_word_t;

  // Word carried through the divider stages
  typedef struct packed {
    seg_t              seg;
    logic [NUM_W-1:0]  rem;
    logic [NUM_W-1:0]  den;
    logic [Q_BITS-1:0] quo;
    logic              full;
    logic              zero;
    logic              eof;
  } div_word_t;

  // Start color of a segment
  function automatic rgb_t seg_lo(input seg_t s);
    rgb_t c;
    case (s)
      SEG_SHALLOW: c = C_SHALLOW;
      SEG_DEEP:    c = C_MID;
      SEG_LAND0:   c = C_DKGREEN;
      SEG_LAND1:   c = C_GREEN;
      SEG_LAND2:   c = C_YELLOW;
      SEG_LAND3:   c = C_ORANGE;
      SEG_LAND4:   c = C_RED;
      SEG_LAND5:   c = C_PURPLE;
      default:     c = C_PURPLE;
    endcase
    return c;
  endfunction

  // End color of a segment
  function automatic rgb_t seg_hi(input seg_t s);
    rgb_t c;
    case (s)
      SEG_SHALLOW: c = C_MID;
      SEG_DEEP:    c = C_DEEP;
      SEG_LAND0:   c = C_GREEN;
      SEG_LAND1:   c = C_YELLOW;
      SEG_LAND2:   c = C_ORANGE;
      SEG_LAND3:   c = C_RED;
      SEG_LAND4:   c = C_PURPLE;
      SEG_LAND5:   c = C_WHITE;
      default:     c = C_WHITE;
    endcase
    return c;
  endfunction

endpackage

FILE: src/elevation_color_ramp.sv
// Elevation color ramp: one signed elevation word in, one RGB word out.
// Register stages: 3 front stages, 16 divider stages, multiply, output register.
// Throughput one word per clock; each stage holds under backpressure and fills bubbles.
// The blend factor comes from a 16-stage pipelined divider, one quotient bit per stage.
// Synchronous active-low reset clears all valid bits and sets the datum register to 0.
// Depends on ecr_pkg, ecr_front, ecr_div and ecr_blend.
module elevation_color_ramp import ecr_pkg::*; (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic signed [ELEV_BITS-1:0] cfg_wr_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  in_word_t                    in_word,
  output logic                        out_valid,
  input  logic                        out_ready,
  output out_word_t                   out_word
);

  logic signed [ELEV_BITS-1:0] datum_r;

  logic      front_valid, front_ready;
  div_word_t front_word;
  logic      div_valid, div_ready;
  div_word_t div_word;

  // Sea-level register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      datum_r <= '0;
    end else if (cfg_wr_en) begin
      datum_r <= cfg_wr_data;
    end
  end

  ecr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .datum     (datum_r),
    .up_valid  (in_valid),
    .up_ready  (in_ready),
    .up_word   (in_word),
    .dn_valid  (front_valid),
    .dn_ready  (front_ready),
    .dn_word   (front_word)
  );

  ecr_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (front_valid),
    .up_ready (front_ready),
    .up_word  (front_word),
    .dn_valid (div_valid),
    .dn_ready (div_ready),
    .dn_word  (div_word)
  );

  ecr_blend u_blend (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (div_valid),
    .up_ready (div_ready),
    .up_word  (div_word),
    .dn_valid (out_valid),
    .dn_ready (out_ready),
    .dn_word  (out_word)
  );

  // Empty output register means every stage can move, so input is ready
  a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("in_ready low with an empty output stage");

  // Reset leaves no word at the output
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid set right after reset");

  // Saturated and zero factor are exclusive
  a_clamp_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    front_valid |-> !(front_word.full && front_word.zero))
    else $error("blend factor flagged both full and zero");

endmodule

FILE: src/ecr_front.sv
// Front end: height/depth difference, segment select and blend-factor clamp.
// Three register stages; depends on ecr_pkg.
module ecr_front import ecr_pkg::*; (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic signed [ELEV_BITS-1:0] datum,
  input  logic                        up_valid,
  output logic                        up_ready,
  input  in_word_t                    up_word,
  output logic                        dn_valid,
  input  logic                        dn_ready,
  output div_word_t                   dn_word
);

  logic v1_r, v2_r, v3_r;
  logic en1, en2, en3;

  logic signed [SPAN_W-1:0] diff1_r, oden1_r;
  logic                     eof1_r;

  seg_t                     seg2_r, seg_nxt;
  logic signed [SPAN_W-1:0] num2_r, den2_r, num_nxt, den_nxt;
  logic                     eof2_r;
  logic signed [SPAN_W-1:0] depth;

  div_word_t word3_r, word_nxt;
  logic      zero_nxt, full_nxt;

  // Stage enables: a stage moves when empty or when its successor moves
  assign en3      = !v3_r || dn_ready;
  assign en2      = !v2_r || en3;
  assign en1      = !v1_r || en2;
  assign up_ready = en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (en1) v1_r <= up_valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
    end
  end

  // Stage 1: height above sea level, deep-ocean span
  always_ff @(posedge clk) begin
    if (en1) begin
      diff1_r <= SPAN_W'(up_word.elevation) - SPAN_W'(datum);
      oden1_r <= SPAN_W'(datum) + OCEAN_DEN_OFS;
      eof1_r  <= up_word.end_of_frame;
    end
  end

  // Stage 2: pick segment, numerator and span
  always_comb begin
    depth   = -diff1_r;
    seg_nxt = SEG_LAND5;
    num_nxt = diff1_r - LAND_B5;
    den_nxt = TOP_SPAN;
    if (diff1_r[SPAN_W-1]) begin
      if (depth < SHALLOW_SPAN) begin
        seg_nxt = SEG_SHALLOW;
        num_nxt = depth;
        den_nxt = SHALLOW_SPAN;
      end else begin
        seg_nxt = SEG_DEEP;
        num_nxt = depth - SHALLOW_SPAN;
        den_nxt = oden1_r;
      end
    end else if (diff1_r < LAND_B1) begin
      seg_nxt = SEG_LAND0;
      num_nxt = diff1_r;
      den_nxt = LAND_B1;
    end else if (diff1_r < LAND_B2) begin
      seg_nxt = SEG_LAND1;
      num_nxt = diff1_r - LAND_B1;
      den_nxt = LAND_B2 - LAND_B1;
    end else if (diff1_r < LAND_B3) begin
      seg_nxt = SEG_LAND2;
      num_nxt = diff1_r - LAND_B2;
      den_nxt = LAND_B3 - LAND_B2;
    end else if (diff1_r < LAND_B4) begin
      seg_nxt = SEG_LAND3;
      num_nxt = diff1_r - LAND_B3;
      den_nxt = LAND_B4 - LAND_B3;
    end else if (diff1_r < LAND_B5) begin
      seg_nxt = SEG_LAND4;
      num_nxt = diff1_r - LAND_B4;
      den_nxt = LAND_B5 - LAND_B4;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      seg2_r <= seg_nxt;
      num2_r <= num_nxt;
      den2_r <= den_nxt;
      eof2_r <= eof1_r;
    end
  end

  // Stage 3: factor is 0 on empty span or non-positive numerator, 1 when num >= den
  always_comb begin
    zero_nxt      = den2_r[SPAN_W-1] || (den2_r == '0) ||
                    num2_r[SPAN_W-1] || (num2_r == '0);
    full_nxt      = !zero_nxt && (num2_r >= den2_r);
    word_nxt.seg  = seg2_r;
    word_nxt.rem  = NUM_W'(num2_r);
    word_nxt.den  = NUM_W'(den2_r);
    word_nxt.quo  = '0;
    word_nxt.full = full_nxt;
    word_nxt.zero = zero_nxt;
    word_nxt.eof  = eof2_r;
  end

  always_ff @(posedge clk) begin
    if (en3) word3_r <= word_nxt;
  end

  assign dn_valid = v3_r;
  assign dn_word  = word3_r;

endmodule

FILE: src/ecr_div.sv
// Pipelined restoring divider: one quotient bit of rem * 2^16 / den per stage.
// Q_BITS register stages; depends on ecr_pkg.
module ecr_div import ecr_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      up_valid,
  output logic      up_ready,
  input  div_word_t up_word,
  output logic      dn_valid,
  input  logic      dn_ready,
  output div_word_t dn_word
);

  div_word_t            stage_r [Q_BITS];
  div_word_t            src_w   [Q_BITS];
  div_word_t            step_nxt[Q_BITS];
  logic [Q_BITS-1:0]    v_r;
  logic [Q_BITS-1:0]    en;
  logic [Q_BITS-1:0]    src_v;

  for (genvar k = 0; k < Q_BITS; k++) begin : g_stage
    logic [NUM_W:0] shifted;
    logic [NUM_W:0] trial;
    logic           take;

    // Source of this stage and its enable
    if (k == 0) begin : g_first
      assign src_w[k] = up_word;
      assign src_v[k] = up_valid;
    end else begin : g_rest
      assign src_w[k] = stage_r[k-1];
      assign src_v[k] = v_r[k-1];
    end

    if (k == Q_BITS - 1) begin : g_last
      assign en[k] = !v_r[k] || dn_ready;
    end else begin : g_mid
      assign en[k] = !v_r[k] || en[k+1];
    end

    // One shift-compare-subtract step
    always_comb begin
      shifted  = {src_w[k].rem, 1'b0};
      trial    = shifted - {1'b0, src_w[k].den};
      take     = (shifted >= {1'b0, src_w[k].den});
      step_nxt[k]     = src_w[k];
      step_nxt[k].rem = take ? trial[NUM_W-1:0] : shifted[NUM_W-1:0];
      step_nxt[k].quo = {src_w[k].quo[Q_BITS-2:0], take};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en[k]) begin
        v_r[k] <= src_v[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en[k]) stage_r[k] <= step_nxt[k];
    end
  end

  assign up_ready = en[0];
  assign dn_valid = v_r[Q_BITS-1];
  assign dn_word  = stage_r[Q_BITS-1];

endmodule

FILE: src/ecr_blend.sv
// Color blend: per-channel lo + (hi - lo) * u, rounded half up.
// Multiply stage then output register; depends on ecr_pkg.
module ecr_blend import ecr_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      up_valid,
  output logic      up_ready,
  input  div_word_t up_word,
  output logic      dn_valid,
  input  logic      dn_ready,
  output out_word_t dn_word
);

  localparam int PROD_W = 27;
  localparam logic signed [PROD_W-1:0] HALF = PROD_W'(32768);

  logic va_r, vb_r;
  logic en_a, en_b;

  logic [U_W-1:0]                fac;
  logic [2:0][7:0]               lo_c, hi_c;
  logic signed [2:0][PROD_W-1:0] prod_nxt;
  logic signed [2:0][PROD_W-1:0] prod_r;
  logic [2:0][7:0]               lo_r;
  logic                          eof_r;

  logic signed [2:0][PROD_W-1:0] sum;
  out_word_t                     word_r, word_nxt;

  assign en_b     = !vb_r || dn_ready;
  assign en_a     = !va_r || en_b;
  assign up_ready = en_a;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else begin
      if (en_a) va_r <= up_valid;
      if (en_b) vb_r <= va_r;
    end
  end

  // Stage A: blend factor and (hi - lo) * u per channel
  always_comb begin
    if (up_word.full) begin
      fac = U_W'(1) << Q_BITS;
    end else if (up_word.zero) begin
      fac = '0;
    end else begin
      fac = {1'b0, up_word.quo};
    end
    lo_c = seg_lo(up_word.seg);
    hi_c = seg_hi(up_word.seg);
    for (int c = 0; c < 3; c++) begin
      prod_nxt[c] = ($signed({1'b0, hi_c[c]}) - $signed({1'b0, lo_c[c]})) *
                    $signed({1'b0, fac});
    end
  end

  always_ff @(posedge clk) begin
    if (en_a) begin
      prod_r <= prod_nxt;
      lo_r   <= lo_c;
      eof_r  <= up_word.eof;
    end
  end

  // Stage B: add start color and rounding half, take the integer byte
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      sum[c] = $signed({3'b000, lo_r[c], 16'h0000}) + prod_r[c] + HALF;
    end
    word_nxt.red        = sum[2][23:16];
    word_nxt.green      = sum[1][23:16];
    word_nxt.blue       = sum[0][23:16];
    word_nxt.frame_done = eof_r;
  end

  always_ff @(posedge clk) begin
    if (en_b) word_r <= word_nxt;
  end

  assign dn_valid = vb_r;
  assign dn_word  = word_r;

endmodule
